### rtl/ght_pkg.sv
`default_nettype none
package ght_pkg;

  // table geometry
  localparam int TABLE_SLOTS = 4096;
  localparam int SLOT_W      = 12;
  localparam int CNT_W       = 13;
  localparam int GEN_W       = 32;
  localparam int DESC_W      = 32;
  localparam int DIN_W       = 31;
  localparam int KIND_W      = 3;
  localparam int MODE_W      = 2;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);

  // operation codes
  localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  // kind and descriptor codes
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [DESC_W-1:0] DESC_INVALID = '1;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_PROC = 2'b10
  } state_t;

endpackage
`default_nettype wire

### rtl/generational_handle_table.sv
`default_nettype none
// sequence: on accept the slot tables and the free stack are read into registers; the processing
//   state then checks the handle, writes the same tables back and registers the result, waiting
//   while a held result is stalled; no new item is accepted until the item completes
// reset: synchronous active-low; clears high-water mark, free count, sequencer and output
//   valid; never-used slots above the high-water mark count as generation zero
module generational_handle_table (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ght_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [ght_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [ght_pkg::DIN_W-1:0]     in_descriptor,
  input  wire logic [ght_pkg::SLOT_W-1:0]    in_handle_slot,
  input  wire logic [ght_pkg::GEN_W-1:0]     in_handle_generation,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_status,
  output logic [ght_pkg::SLOT_W-1:0]         out_new_slot,
  output logic [ght_pkg::GEN_W-1:0]          out_new_generation,
  output logic signed [ght_pkg::DESC_W-1:0]  out_found_descriptor
);
  import ght_pkg::*;

  // slot tables and free stack
  logic [GEN_W-1:0]  gen_mem   [TABLE_SLOTS];
  logic [DESC_W-1:0] desc_mem  [TABLE_SLOTS];
  logic [KIND_W-1:0] kind_mem  [TABLE_SLOTS];
  logic [SLOT_W-1:0] stack_mem [TABLE_SLOTS];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  hw_r, hw_nxt;
  logic [CNT_W-1:0]  fc_r, fc_nxt;
  logic [SLOT_W-1:0] top_r, top_nxt;

  logic [MODE_W-1:0] mode_r;
  logic [KIND_W-1:0] kind_r;
  logic [DIN_W-1:0]  desc_r;
  logic [SLOT_W-1:0] hslot_r;
  logic [GEN_W-1:0]  hgen_r;

  logic [GEN_W-1:0]  gen_rd;
  logic [DESC_W-1:0] desc_rd;
  logic [KIND_W-1:0] kind_rd;
  logic [SLOT_W-1:0] stack_rd;

  logic              out_valid_r;
  logic              out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [GEN_W-1:0]  out_gen_r;
  logic [DESC_W-1:0] out_desc_r;

  logic              accept;
  logic              done;
  logic [SLOT_W-1:0] create_slot;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] pop_addr;

  logic              res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [GEN_W-1:0]  res_gen;
  logic [DESC_W-1:0] res_desc;

  logic              slot_we;
  logic [GEN_W-1:0]  gen_wd;
  logic [DESC_W-1:0] desc_wd;
  logic [KIND_W-1:0] kind_wd;
  logic [SLOT_W-1:0] slot_wa;
  logic              push_we;

  logic              live;
  logic [CNT_W-1:0]  pop_idx;

  // handshake
  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign done     = (state_r == S_PROC) && (!out_valid_r || !out_stall);

  // slot a create would take: top of the free stack, else the high-water slot
  assign create_slot = (fc_r != '0) ? top_r : hw_r[SLOT_W-1:0];
  assign rd_addr     = (in_mode == MODE_CREATE) ? create_slot : in_handle_slot;
  assign pop_idx     = fc_r - CNT_W'(2);
  assign pop_addr    = pop_idx[SLOT_W-1:0];

  // table reads on accept, writes when the item completes
  always_ff @(posedge clk) begin
    if (accept) begin
      gen_rd <= gen_mem[rd_addr];
    end
    if (slot_we) begin
      gen_mem[slot_wa] <= gen_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_rd <= desc_mem[rd_addr];
    end
    if (slot_we) begin
      desc_mem[slot_wa] <= desc_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_rd <= kind_mem[rd_addr];
    end
    if (slot_we) begin
      kind_mem[slot_wa] <= kind_wd;
    end
  end

  // entry below the top, so the cached top can be refilled on a pop
  always_ff @(posedge clk) begin
    if (accept) begin
      stack_rd <= stack_mem[pop_addr];
    end
    if (push_we) begin
      stack_mem[fc_r[SLOT_W-1:0]] <= hslot_r;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      kind_r  <= in_kind;
      desc_r  <= in_descriptor;
      hslot_r <= in_handle_slot;
      hgen_r  <= in_handle_generation;
    end
  end

  // handle check and table update
  always_comb begin
    res_status = STATUS_FAIL;
    res_slot   = '0;
    res_gen    = '0;
    res_desc   = DESC_INVALID;
    slot_we    = 1'b0;
    slot_wa    = hslot_r;
    gen_wd     = gen_rd;
    desc_wd    = DESC_INVALID;
    kind_wd    = KIND_NONE;
    push_we    = 1'b0;
    hw_nxt     = hw_r;
    fc_nxt     = fc_r;
    top_nxt    = top_r;
    live       = ({1'b0, hslot_r} < hw_r) && (gen_rd == hgen_r);
    unique case (mode_r)
      MODE_CREATE: begin
        if (fc_r != '0) begin
          fc_nxt     = fc_r - CNT_W'(1);
          top_nxt    = stack_rd;
          res_gen    = gen_rd + GEN_W'(1);
          res_status = STATUS_OK;
        end else if (hw_r < SLOTS_CNT) begin
          // never used since reset: generation starts from zero
          hw_nxt     = hw_r + CNT_W'(1);
          res_gen    = GEN_W'(1);
          res_status = STATUS_OK;
        end
        if (res_status == STATUS_OK) begin
          res_slot = create_slot;
          slot_we  = done;
          slot_wa  = create_slot;
          gen_wd   = res_gen;
          desc_wd  = {1'b0, desc_r};
          kind_wd  = kind_r;
        end
      end
      MODE_LOOKUP: begin
        if (live && (kind_r == KIND_NONE || kind_rd == kind_r)) begin
          res_desc = desc_rd;
        end
        res_status = (res_desc == DESC_INVALID) ? STATUS_FAIL : STATUS_OK;
      end
      MODE_RELEASE: begin
        if (live && !desc_rd[DESC_W-1]) begin
          res_desc   = desc_rd;
          res_status = STATUS_OK;
          slot_we    = done;
          if (fc_r < SLOTS_CNT) begin
            push_we = done;
            fc_nxt  = fc_r + CNT_W'(1);
            top_nxt = hslot_r;
          end
        end
      end
      default: begin
        // unused mode: fail with no state change
        res_status = STATUS_FAIL;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_PROC;
      end
      S_PROC: begin
        if (done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hw_r    <= '0;
      fc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        hw_r <= hw_nxt;
        fc_r <= fc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      top_r <= top_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_gen_r    <= res_gen;
      out_desc_r   <= res_desc;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_new_slot         = out_slot_r;
  assign out_new_generation   = out_gen_r;
  assign out_found_descriptor = out_desc_r;

endmodule
`default_nettype wire
